// ===== rtl/mbph_pkg.sv =====
package mbph_pkg;

   localparam int MAX_PROJECTILES = 1024;
   localparam int MAX_HORIZON = 600;
   localparam int QUEUE_DEPTH = 2;

   localparam int IDX_W = (MAX_PROJECTILES > 1) ? $clog2(MAX_PROJECTILES) : 1;
   localparam int PC_W = $clog2(MAX_PROJECTILES + 1);
   localparam int FRM_W = $clog2(MAX_HORIZON + 1);
   localparam int CW = ((FRM_W > 10) ? FRM_W : 10) + 1;
   localparam int FF_W = 2 * FRM_W;
   localparam int MB_W = (FF_W > CW) ? FF_W : CW;
   localparam int MP_W = 32 + MB_W + 1;
   localparam int SC_W = ((PC_W > 10) ? PC_W : 10) + 1;
   localparam int NC_W = ((PC_W > 11) ? PC_W : 11) + 1;
   localparam int GAP_W = 35;
   localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_W = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_H = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HORIZON = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 3'd6;

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_EVAL = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;
   localparam logic [1:0] KIND_DROP = 2'd3;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] acc_x;
      logic signed [31:0] acc_y;
      logic [30:0]        half_w;
      logic [30:0]        half_h;
   } tab_entry_type;

   typedef struct packed {
      logic [1:0]    kind;
      logic [9:0]    slot;
      tab_entry_type data;
      logic [9:0]    graze;
      logic [9:0]    startup;
   } work_type;

   typedef struct packed {
      logic signed [31:0] player_x;
      logic signed [31:0] player_y;
      logic [30:0]        half_w;
      logic [30:0]        half_h;
      logic signed [31:0] margin;
      logic [9:0]         horizon;
      logic [10:0]        count;
   } cfg_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [FRM_W-1:0] eff_horizon(input logic [9:0] hz);
      if (hz == 10'd0) return FRM_W'(1);
      if (CW'(hz) > CW'(MAX_HORIZON)) return FRM_W'(MAX_HORIZON);
      return FRM_W'(hz);
   endfunction

   function automatic logic [PC_W-1:0] eff_count(input logic [10:0] c);
      if (NC_W'(c) > NC_W'(MAX_PROJECTILES)) return PC_W'(MAX_PROJECTILES);
      return PC_W'(c);
   endfunction

endpackage

// ===== rtl/mbph_if.sv =====
interface mbph_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic [9:0]         slot;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic [30:0]        half_w;
   logic [30:0]        half_h;
   logic signed [31:0] acc_x;
   logic signed [31:0] acc_y;
   logic [9:0]         graze_frames;
   logic [9:0]         startup_frames;

   modport source (output valid, action, slot, pos_x, pos_y, vel_x, vel_y, half_w, half_h,
                   acc_x, acc_y, graze_frames, startup_frames, input ready);
   modport sink (input valid, action, slot, pos_x, pos_y, vel_x, vel_y, half_w, half_h,
                 acc_x, acc_y, graze_frames, startup_frames, output ready);
endinterface

interface mbph_rsp_if;
   logic               valid;
   logic               ready;
   logic               status;
   logic [9:0]         candidate_index;
   logic               safe;
   logic signed [10:0] first_hit_frame;
   logic signed [31:0] min_clearance;
   logic signed [31:0] final_x;
   logic signed [31:0] final_y;

   modport source (output valid, status, candidate_index, safe, first_hit_frame,
                   min_clearance, final_x, final_y, input ready);
   modport sink (input valid, status, candidate_index, safe, first_hit_frame,
                 min_clearance, final_x, final_y, output ready);
endinterface

// ===== rtl/mbph_front.sv =====
module mbph_front import mbph_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   mbph_req_if.sink req,
   input  cfg_type  cfg,
   output logic     wk_valid,
   output work_type wk,
   input  logic     wk_ready
);

   work_type          q_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QC_W-1:0]   cnt_ff, cnt_in;
   work_type          item;
   logic [FRM_W-1:0]  h;
   logic              push, pop;

   always_comb begin
      h = eff_horizon(cfg.horizon);
      item.slot = req.slot;
      item.data.pos_x = req.pos_x;
      item.data.pos_y = req.pos_y;
      item.data.vel_x = req.vel_x;
      item.data.vel_y = req.vel_y;
      item.data.acc_x = req.acc_x;
      item.data.acc_y = req.acc_y;
      item.data.half_w = req.half_w;
      item.data.half_h = req.half_h;
      item.graze = req.graze_frames;
      item.startup = req.startup_frames;
      if (!req.action) begin
         item.kind = (SC_W'(req.slot) < SC_W'(MAX_PROJECTILES)) ? KIND_LOAD : KIND_DROP;
      end else if (CW'(req.graze_frames) > CW'(h) || CW'(req.startup_frames) > CW'(h)) begin
         item.kind = KIND_ERROR;
      end else begin
         item.kind = KIND_EVAL;
      end
   end

   assign req.ready = (cnt_ff != QC_W'(QUEUE_DEPTH));
   assign wk_valid = (cnt_ff != '0);
   assign wk = q_ff[rd_ff];
   assign push = req.valid && req.ready && (item.kind != KIND_DROP);
   assign pop = wk_valid && wk_ready;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : QP_W'(wr_ff + 1'b1);
      end
      if (pop) begin
         rd_in = (rd_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : QP_W'(rd_ff + 1'b1);
      end
      if (push && !pop) begin
         cnt_in = QC_W'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = QC_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= item;
      end
   end

endmodule

// ===== rtl/mbph_isqrt.sv =====
module mbph_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] n,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff, busy_in, done_ff, done_in;
   logic [63:0] rem_ff, rem_in, r_ff, r_in, bit_ff, bit_in;
   logic [63:0] trial;

   assign trial = r_ff + bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      r_in = r_ff;
      bit_in = bit_ff;
      if (start) begin
         rem_in = n;
         r_in = '0;
         bit_in = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 64'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      r_ff <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[31:0];

endmodule

// ===== rtl/mbph_back.sv =====
module mbph_back import mbph_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       wk_valid,
   input  work_type   wk,
   output logic       wk_ready,
   mbph_rsp_if.source rsp
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_FRAME = 5'd1;
   localparam logic [4:0] ST_PMX   = 5'd2;
   localparam logic [4:0] ST_PMY   = 5'd3;
   localparam logic [4:0] ST_PSAT  = 5'd4;
   localparam logic [4:0] ST_RD    = 5'd5;
   localparam logic [4:0] ST_HVX   = 5'd6;
   localparam logic [4:0] ST_HAX   = 5'd7;
   localparam logic [4:0] ST_HX    = 5'd8;
   localparam logic [4:0] ST_HAY   = 5'd9;
   localparam logic [4:0] ST_HY    = 5'd10;
   localparam logic [4:0] ST_GAP   = 5'd11;
   localparam logic [4:0] ST_CLS   = 5'd12;
   localparam logic [4:0] ST_SQX   = 5'd13;
   localparam logic [4:0] ST_SQY   = 5'd14;
   localparam logic [4:0] ST_SUM   = 5'd15;
   localparam logic [4:0] ST_ROOT  = 5'd16;
   localparam logic [4:0] ST_UPD   = 5'd17;
   localparam logic [4:0] ST_NEXTF = 5'd18;
   localparam logic [4:0] ST_FIN1  = 5'd19;
   localparam logic [4:0] ST_FIN2  = 5'd20;
   localparam logic [4:0] ST_FIN3  = 5'd21;
   localparam logic [4:0] ST_OUT   = 5'd22;

   function automatic logic [30:0] clip31(input logic signed [GAP_W-1:0] g);
      if (g <= 0) return '0;
      if (g > 35'sd2147483647) return 31'h7FFFFFFF;
      return g[30:0];
   endfunction

   function automatic logic signed [GAP_W-1:0] box_gap(input logic signed [31:0] a,
                                                       input logic signed [31:0] b,
                                                       input logic [30:0] ha,
                                                       input logic [30:0] hb);
      logic signed [32:0] d;
      logic [32:0]        ad;
      d = 33'(a) - 33'(b);
      ad = d[32] ? 33'(-d) : 33'(d);
      return $signed({2'b00, ad}) - $signed({4'b0000, ha}) - $signed({4'b0000, hb});
   endfunction

   tab_entry_type mem [MAX_PROJECTILES];
   tab_entry_type rdata_ff;

   logic [4:0]  state_ff, state_in;
   logic [FRM_W-1:0] f_ff, f_in, h_ff, h_in, first_ff, first_in;
   logic [PC_W-1:0]  i_ff, i_in, cnt_ff, cnt_in;
   logic        hit_ff, hit_in, err_ff, err_in, out_valid_ff, out_valid_in;
   logic signed [31:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [30:0] hw_ff, hw_in, hh_ff, hh_in;
   logic [9:0]  s_ff, s_in, g_ff, g_in, slot_ff, slot_in;
   logic [CW-1:0]   m_ff, m_in;
   logic [FF_W-1:0] ff_ff, ff_in;
   logic signed [MP_W-1:0] prod_ff, prod_in, pa_ff, pa_in, mul_p;
   logic signed [31:0] x_ff, x_in, y_ff, y_in, hx_ff, hx_in, hy_ff, hy_in;
   logic signed [GAP_W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [30:0] ux_ff, ux_in, uy_ff, uy_in, sq_op;
   logic [61:0] sq_ff, sq_in, sqa_ff, sqa_in, sq_p;
   logic signed [31:0] c_ff, c_in, minc_ff, minc_in, fx_ff, fx_in, fy_ff, fy_in;
   logic        out_status_ff, out_status_in, out_safe_ff, out_safe_in;
   logic [9:0]  out_index_ff, out_index_in;
   logic signed [10:0] out_first_ff, out_first_in;
   logic signed [31:0] out_min_ff, out_min_in, out_fx_ff, out_fx_in, out_fy_ff, out_fy_in;

   logic signed [31:0] mul_a;
   logic [MB_W-1:0]    mul_b;
   logic        mem_we, skip, out_load, sq_start, sq_done;
   logic [63:0] sq_n;
   logic [31:0] sq_root;

   assign mul_p = $signed(MP_W'(mul_a)) * $signed(MP_W'({1'b0, mul_b}));
   assign sq_p = 62'(sq_op) * 62'(sq_op);
   assign sq_n = 64'(sqa_ff) + 64'(sq_ff);

   mbph_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .n     (sq_n),
      .done  (sq_done),
      .root  (sq_root)
   );

   always_comb begin
      state_in = state_ff;
      f_in = f_ff;
      h_in = h_ff;
      first_in = first_ff;
      i_in = i_ff;
      cnt_in = cnt_ff;
      hit_in = hit_ff;
      err_in = err_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      hw_in = hw_ff;
      hh_in = hh_ff;
      s_in = s_ff;
      g_in = g_ff;
      slot_in = slot_ff;
      m_in = m_ff;
      ff_in = ff_ff;
      prod_in = prod_ff;
      pa_in = pa_ff;
      x_in = x_ff;
      y_in = y_ff;
      hx_in = hx_ff;
      hy_in = hy_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      ux_in = ux_ff;
      uy_in = uy_ff;
      sq_in = sq_ff;
      sqa_in = sqa_ff;
      c_in = c_ff;
      minc_in = minc_ff;
      fx_in = fx_ff;
      fy_in = fy_ff;
      wk_ready = 1'b0;
      mem_we = 1'b0;
      skip = 1'b0;
      out_load = 1'b0;
      sq_start = 1'b0;
      sq_op = '0;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_IDLE: begin
            wk_ready = 1'b1;
            if (wk_valid) begin
               case (wk.kind)
                  KIND_LOAD: begin
                     mem_we = 1'b1;
                  end
                  KIND_ERROR: begin
                     err_in = 1'b1;
                     hit_in = 1'b0;
                     slot_in = wk.slot;
                     state_in = ST_OUT;
                  end
                  KIND_EVAL: begin
                     err_in = 1'b0;
                     slot_in = wk.slot;
                     vx_in = wk.data.vel_x;
                     vy_in = wk.data.vel_y;
                     hw_in = (wk.data.half_w == '0) ? cfg.half_w : wk.data.half_w;
                     hh_in = (wk.data.half_h == '0) ? cfg.half_h : wk.data.half_h;
                     s_in = wk.startup;
                     g_in = wk.graze;
                     h_in = eff_horizon(cfg.horizon);
                     cnt_in = eff_count(cfg.count);
                     f_in = FRM_W'(1);
                     hit_in = 1'b0;
                     minc_in = 32'sh7FFFFFFF;
                     state_in = ST_FRAME;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FRAME: begin
            ff_in = FF_W'(f_ff) * FF_W'(f_ff);
            if (CW'(f_ff) > CW'(s_ff)) begin
               m_in = CW'(f_ff) - CW'(s_ff);
               skip = (CW'(f_ff) <= CW'(s_ff) + CW'(g_ff));
            end else begin
               m_in = '0;
            end
            state_in = skip ? ST_NEXTF : ST_PMX;
         end
         ST_PMX: begin
            mul_a = vx_ff;
            mul_b = MB_W'(m_ff);
            prod_in = mul_p;
            state_in = ST_PMY;
         end
         ST_PMY: begin
            x_in = sat32(64'(cfg.player_x) + 64'(prod_ff));
            mul_a = vy_ff;
            mul_b = MB_W'(m_ff);
            prod_in = mul_p;
            state_in = ST_PSAT;
         end
         ST_PSAT: begin
            y_in = sat32(64'(cfg.player_y) + 64'(prod_ff));
            i_in = '0;
            state_in = (cnt_ff == '0) ? ST_NEXTF : ST_RD;
         end
         ST_RD: begin
            state_in = ST_HVX;
         end
         ST_HVX: begin
            mul_a = rdata_ff.vel_x;
            mul_b = MB_W'(f_ff);
            prod_in = mul_p;
            state_in = ST_HAX;
         end
         ST_HAX: begin
            pa_in = prod_ff;
            mul_a = rdata_ff.acc_x;
            mul_b = MB_W'(ff_ff);
            prod_in = mul_p;
            state_in = ST_HX;
         end
         ST_HX: begin
            hx_in = sat32(64'(rdata_ff.pos_x) + 64'(pa_ff) + 64'(prod_ff >>> 1));
            mul_a = rdata_ff.vel_y;
            mul_b = MB_W'(f_ff);
            prod_in = mul_p;
            state_in = ST_HAY;
         end
         ST_HAY: begin
            pa_in = prod_ff;
            mul_a = rdata_ff.acc_y;
            mul_b = MB_W'(ff_ff);
            prod_in = mul_p;
            state_in = ST_HY;
         end
         ST_HY: begin
            hy_in = sat32(64'(rdata_ff.pos_y) + 64'(pa_ff) + 64'(prod_ff >>> 1));
            state_in = ST_GAP;
         end
         ST_GAP: begin
            gx_in = box_gap(x_ff, hx_ff, hw_ff, rdata_ff.half_w);
            gy_in = box_gap(y_ff, hy_ff, hh_ff, rdata_ff.half_h);
            state_in = ST_CLS;
         end
         ST_CLS: begin
            if (gx_ff <= 0 && gy_ff <= 0) begin
               c_in = sat32(64'((gx_ff > gy_ff) ? gx_ff : gy_ff));
               state_in = ST_UPD;
            end else begin
               ux_in = clip31(gx_ff);
               uy_in = clip31(gy_ff);
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            sq_op = ux_ff;
            sq_in = sq_p;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sqa_in = sq_ff;
            sq_op = uy_ff;
            sq_in = sq_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sq_start = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sq_done) begin
               c_in = sq_root[31] ? 32'sh7FFFFFFF : $signed(sq_root);
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (c_ff < minc_ff) begin
               minc_in = c_ff;
            end
            if (c_ff <= cfg.margin && !hit_ff) begin
               hit_in = 1'b1;
               first_in = f_ff;
            end
            i_in = PC_W'(i_ff + 1'b1);
            state_in = (PC_W'(i_ff + 1'b1) == cnt_ff) ? ST_NEXTF : ST_RD;
         end
         ST_NEXTF: begin
            if (f_ff == h_ff) begin
               state_in = ST_FIN1;
            end else begin
               f_in = FRM_W'(f_ff + 1'b1);
               state_in = ST_FRAME;
            end
         end
         ST_FIN1: begin
            mul_a = vx_ff;
            mul_b = MB_W'(CW'(h_ff) - CW'(s_ff));
            prod_in = mul_p;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            fx_in = sat32(64'(cfg.player_x) + 64'(prod_ff));
            mul_a = vy_ff;
            mul_b = MB_W'(CW'(h_ff) - CW'(s_ff));
            prod_in = mul_p;
            state_in = ST_FIN3;
         end
         ST_FIN3: begin
            fy_in = sat32(64'(cfg.player_y) + 64'(prod_ff));
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result word
   always_comb begin
      out_valid_in = out_valid_ff && !rsp.ready;
      out_status_in = out_status_ff;
      out_index_in = out_index_ff;
      out_safe_in = out_safe_ff;
      out_first_in = out_first_ff;
      out_min_in = out_min_ff;
      out_fx_in = out_fx_ff;
      out_fy_in = out_fy_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_index_in = slot_ff;
         if (err_ff) begin
            out_status_in = 1'b1;
            out_safe_in = 1'b0;
            out_first_in = -11'sd1;
            out_min_in = '0;
            out_fx_in = '0;
            out_fy_in = '0;
         end else begin
            out_status_in = 1'b0;
            out_safe_in = !hit_ff;
            out_first_in = hit_ff ? $signed(11'(first_ff)) : -11'sd1;
            out_min_in = minc_ff;
            out_fx_in = fx_ff;
            out_fy_in = fy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         f_ff <= '0;
         i_ff <= '0;
         hit_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         f_ff <= f_in;
         i_ff <= i_in;
         hit_ff <= hit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      first_ff <= first_in;
      cnt_ff <= cnt_in;
      err_ff <= err_in;
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      hw_ff <= hw_in;
      hh_ff <= hh_in;
      s_ff <= s_in;
      g_ff <= g_in;
      slot_ff <= slot_in;
      m_ff <= m_in;
      ff_ff <= ff_in;
      prod_ff <= prod_in;
      pa_ff <= pa_in;
      x_ff <= x_in;
      y_ff <= y_in;
      hx_ff <= hx_in;
      hy_ff <= hy_in;
      gx_ff <= gx_in;
      gy_ff <= gy_in;
      ux_ff <= ux_in;
      uy_ff <= uy_in;
      sq_ff <= sq_in;
      sqa_ff <= sqa_in;
      c_ff <= c_in;
      minc_ff <= minc_in;
      fx_ff <= fx_in;
      fy_ff <= fy_in;
      out_status_ff <= out_status_in;
      out_index_ff <= out_index_in;
      out_safe_ff <= out_safe_in;
      out_first_ff <= out_first_in;
      out_min_ff <= out_min_in;
      out_fx_ff <= out_fx_in;
      out_fy_ff <= out_fy_in;
   end

   // projectile table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[IDX_W'(wk.slot)] <= wk.data;
      end
      rdata_ff <= mem[i_ff[IDX_W-1:0]];
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.status = out_status_ff;
   assign rsp.candidate_index = out_index_ff;
   assign rsp.safe = out_safe_ff;
   assign rsp.first_hit_frame = out_first_ff;
   assign rsp.min_clearance = out_min_ff;
   assign rsp.final_x = out_fx_ff;
   assign rsp.final_y = out_fy_ff;

   a_root_state: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> state_ff == ST_ROOT)
      else $error("square root finished outside its wait state");

   a_hit_margin: assert property (@(posedge clock) disable iff (reset)
      hit_ff && state_ff != ST_IDLE |-> minc_ff <= cfg.margin)
      else $error("hit recorded but least clearance above margin");

   a_pair_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HVX |-> i_ff < cnt_ff)
      else $error("projectile index past count");

   a_out_error: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff |-> !out_safe_ff && out_min_ff == '0)
      else $error("error word carries evaluation data");

   a_out_safe: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_status_ff |-> out_safe_ff == (out_first_ff == -11'sd1))
      else $error("safe flag disagrees with first hit frame");

endmodule

// ===== rtl/moving_box_path_hazard_check.sv =====
// Swept box clearance checker. Load words write one projectile into the table; an
// evaluate word walks frames 1..horizon and, for every frame outside the graze window,
// every projectile in use, one pair at a time through a shared multiplier. Pairs whose
// boxes overlap skip the 32-step bitwise square root that pairs set apart go through,
// and each evaluate adds a setup step and a final position step.
// A two-word queue in front lets new words be taken while an evaluation runs, and a
// result register lets the next word start while a result waits.
module moving_box_path_hazard_check import mbph_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mbph_req_if.sink              req_ch,
   mbph_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     wk_valid, wk_ready;
   work_type wk;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PLAYER_X: cfg_in.player_x = $signed(csr_data);
            CSR_PLAYER_Y: cfg_in.player_y = $signed(csr_data);
            CSR_HALF_W:   cfg_in.half_w = csr_data[30:0];
            CSR_HALF_H:   cfg_in.half_h = csr_data[30:0];
            CSR_MARGIN:   cfg_in.margin = $signed(csr_data);
            CSR_HORIZON:  cfg_in.horizon = csr_data[9:0];
            CSR_COUNT:    cfg_in.count = csr_data[10:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{horizon: 10'd1, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbph_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .cfg      (cfg_ff),
      .wk_valid (wk_valid),
      .wk       (wk),
      .wk_ready (wk_ready)
   );

   mbph_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .wk_valid (wk_valid),
      .wk       (wk),
      .wk_ready (wk_ready),
      .rsp      (rsp_ch)
   );

endmodule

// ===== bench/mbph_checker.sv =====
`timescale 1ns / 1ps

module mbph_checker import mbph_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mbph_req_if                   req_ch,
   mbph_rsp_if                   rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic               status;
      logic [9:0]         cand;
      logic               safe;
      logic signed [10:0] first_hit;
      logic signed [31:0] min_clr;
      logic signed [31:0] fin_x;
      logic signed [31:0] fin_y;
   } verdict_type;

   verdict_type verdicts[$];

   longint pl_x, pl_y, pl_hw, pl_hh, clr_margin;
   int     hz_reg, cnt_reg;

   logic signed [31:0] hz_px[MAX_PROJECTILES], hz_py[MAX_PROJECTILES];
   logic signed [31:0] hz_vx[MAX_PROJECTILES], hz_vy[MAX_PROJECTILES];
   logic signed [31:0] hz_ax[MAX_PROJECTILES], hz_ay[MAX_PROJECTILES];
   logic [30:0]        hz_hw[MAX_PROJECTILES], hz_hh[MAX_PROJECTILES];

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned root64(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint path_pos(longint p, longint v, longint a, longint f);
      longint acc;
      acc = a * f * f;
      return clamp32(p + v * f + (acc >>> 1));
   endfunction

   function automatic longint box_gap(longint px, longint py, longint phw, longint phh,
                                      longint hx, longint hy, longint hhw, longint hhh);
      longint dx, dy, gx, gy;
      longint unsigned ux, uy;
      dx = px - hx;
      dy = py - hy;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      gx = dx - phw - hhw;
      gy = dy - phh - hhh;
      if (gx <= 0 && gy <= 0) return clamp32(gx > gy ? gx : gy);
      ux = gx > 0 ? (gx > 64'sd2147483647 ? 64'd2147483647 : gx) : 0;
      uy = gy > 0 ? (gy > 64'sd2147483647 ? 64'd2147483647 : gy) : 0;
      return clamp32(longint'(root64(ux * ux + uy * uy)));
   endfunction

   function automatic verdict_type judge_move();
      verdict_type o;
      longint h, s, g, n, f, m, x, y, vx, vy, hw, hh, c, minc, first;
      h = hz_reg;
      if (h < 1) h = 1;
      if (h > MAX_HORIZON) h = MAX_HORIZON;
      n = cnt_reg;
      if (n > MAX_PROJECTILES) n = MAX_PROJECTILES;
      g = req_ch.graze_frames;
      s = req_ch.startup_frames;
      o = '0;
      o.cand = req_ch.slot;
      if (g > h || s > h) begin
         o.status = 1'b1;
         o.first_hit = -11'sd1;
         return o;
      end
      vx = req_ch.vel_x;
      vy = req_ch.vel_y;
      hw = req_ch.half_w == 0 ? pl_hw : longint'(req_ch.half_w);
      hh = req_ch.half_h == 0 ? pl_hh : longint'(req_ch.half_h);
      minc = 64'sd2147483647;
      first = -1;
      for (f = 1; f <= h; f++) begin
         if (f > s && f <= s + g) continue;
         m = f > s ? f - s : 0;
         x = clamp32(pl_x + vx * m);
         y = clamp32(pl_y + vy * m);
         for (int i = 0; i < n; i++) begin
            c = box_gap(x, y, hw, hh,
                        path_pos(hz_px[i], hz_vx[i], hz_ax[i], f),
                        path_pos(hz_py[i], hz_vy[i], hz_ay[i], f),
                        longint'(hz_hw[i]), longint'(hz_hh[i]));
            if (c < minc) minc = c;
            if (c <= clr_margin && first < 0) first = f;
         end
      end
      o.safe = first < 0;
      o.first_hit = first[10:0];
      o.min_clr = minc[31:0];
      x = clamp32(pl_x + vx * (h - s));
      y = clamp32(pl_y + vy * (h - s));
      o.fin_x = x[31:0];
      o.fin_y = y[31:0];
      return o;
   endfunction

   initial fail_count = 0;
   initial pending = 0;

   always @(posedge clock) begin
      verdict_type e, a;
      if (reset) begin
         pl_x = 0; pl_y = 0; pl_hw = 0; pl_hh = 0; clr_margin = 0;
         hz_reg = 1; cnt_reg = 0;
         verdicts.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PLAYER_X: pl_x = $signed(csr_data);
               CSR_PLAYER_Y: pl_y = $signed(csr_data);
               CSR_HALF_W:   pl_hw = csr_data[30:0];
               CSR_HALF_H:   pl_hh = csr_data[30:0];
               CSR_MARGIN:   clr_margin = $signed(csr_data);
               CSR_HORIZON:  hz_reg = csr_data[9:0];
               CSR_COUNT:    cnt_reg = csr_data[10:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.action == 1'b0) begin
               hz_px[req_ch.slot] = req_ch.pos_x;
               hz_py[req_ch.slot] = req_ch.pos_y;
               hz_vx[req_ch.slot] = req_ch.vel_x;
               hz_vy[req_ch.slot] = req_ch.vel_y;
               hz_ax[req_ch.slot] = req_ch.acc_x;
               hz_ay[req_ch.slot] = req_ch.acc_y;
               hz_hw[req_ch.slot] = req_ch.half_w;
               hz_hh[req_ch.slot] = req_ch.half_h;
            end else begin
               verdicts.push_back(judge_move());
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            a.status = rsp_ch.status;
            a.cand = rsp_ch.candidate_index;
            a.safe = rsp_ch.safe;
            a.first_hit = rsp_ch.first_hit_frame;
            a.min_clr = rsp_ch.min_clearance;
            a.fin_x = rsp_ch.final_x;
            a.fin_y = rsp_ch.final_y;
            if (verdicts.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result word %h", $time, a);
            end else begin
               e = verdicts.pop_front();
               if (e.status != a.status || e.cand != a.cand || e.safe != a.safe ||
                   e.first_hit != a.first_hit || e.min_clr != a.min_clr ||
                   e.fin_x != a.fin_x || e.fin_y != a.fin_y) begin
                  fail_count++;
                  $display("%0t: mismatch exp st=%0d idx=%0d safe=%0d hit=%0d clr=%0d x=%0d y=%0d",
                           $time, e.status, e.cand, e.safe, e.first_hit, e.min_clr,
                           e.fin_x, e.fin_y);
                  $display("%0t:          act st=%0d idx=%0d safe=%0d hit=%0d clr=%0d x=%0d y=%0d",
                           $time, a.status, a.cand, a.safe, a.first_hit, a.min_clr,
                           a.fin_x, a.fin_y);
               end
            end
         end
      end
      pending = verdicts.size();
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import mbph_pkg::*;

   typedef struct {
      logic               action;
      logic [9:0]         slot;
      logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
      logic [30:0]        half_w, half_h;
      logic [9:0]         graze, startup;
   } word_type;

   logic                  clock, reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    fail_count, pending;
   int                    idle_pct, stall_pct;
   logic                  hold_go, hold_taken;
   int                    hold_left;
   int                    n_load, n_eval, contig;
   bit                    written[MAX_PROJECTILES];
   int                    cur_hz;

   mbph_req_if req_ch();
   mbph_rsp_if rsp_ch();

   moving_box_path_hazard_check i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   mbph_checker i_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("moving_box_path_hazard_check test failed");
      $finish;
   end

   // result side: random stalls plus one long hold-off
   initial begin
      rsp_ch.ready = 0;
      hold_taken = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_taken) begin
            hold_taken = 1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   function automatic logic [31:0] rnd_q();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h7FFFFFFF;
         2: return 32'h80000000;
         3: return 0;
         default: return $urandom_range(0, 32'h00140000) - 32'h000A0000;
      endcase
   endfunction

   function automatic logic [30:0] rnd_half();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 31'h7FFFFFFF;
         2: return 0;
         default: return $urandom_range(0, 32'h00030000);
      endcase
   endfunction

   task automatic send(word_type w);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= w.action;
      req_ch.slot <= w.slot;
      req_ch.pos_x <= w.pos_x;
      req_ch.pos_y <= w.pos_y;
      req_ch.vel_x <= w.vel_x;
      req_ch.vel_y <= w.vel_y;
      req_ch.acc_x <= w.acc_x;
      req_ch.acc_y <= w.acc_y;
      req_ch.half_w <= w.half_w;
      req_ch.half_h <= w.half_h;
      req_ch.graze_frames <= w.graze;
      req_ch.startup_frames <= w.startup;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      if (w.action == 1'b0) begin
         n_load++;
         written[w.slot] = 1;
         while (contig < MAX_PROJECTILES && written[contig]) contig++;
      end else begin
         n_eval++;
      end
   endtask

   task automatic load(logic [9:0] slot);
      word_type w;
      w.action = 1'b0;
      w.slot = slot;
      w.pos_x = rnd_q(); w.pos_y = rnd_q();
      w.vel_x = rnd_q(); w.vel_y = rnd_q();
      w.acc_x = $urandom_range(0, 3) == 0 ? rnd_q() : $signed($urandom_range(0, 4096)) - 2048;
      w.acc_y = $urandom_range(0, 3) == 0 ? rnd_q() : $signed($urandom_range(0, 4096)) - 2048;
      w.half_w = rnd_half(); w.half_h = rnd_half();
      w.graze = $urandom; w.startup = $urandom;
      send(w);
   endtask

   task automatic evaluate(logic [9:0] graze, logic [9:0] startup);
      word_type w;
      w.action = 1'b1;
      w.slot = $urandom;
      w.pos_x = $urandom; w.pos_y = $urandom;
      w.acc_x = $urandom; w.acc_y = $urandom;
      w.vel_x = rnd_q(); w.vel_y = rnd_q();
      w.half_w = $urandom_range(0, 1) ? 31'd0 : rnd_half();
      w.half_h = $urandom_range(0, 1) ? 31'd0 : rnd_half();
      w.graze = graze; w.startup = startup;
      send(w);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_HORIZON) begin
         cur_hz = data[9:0];
         if (cur_hz < 1) cur_hz = 1;
         if (cur_hz > MAX_HORIZON) cur_hz = MAX_HORIZON;
      end
   endtask

   task automatic random_setup();
      int c;
      c = contig < 6 ? contig : 6;
      csr_write(CSR_PLAYER_X, rnd_q());
      csr_write(CSR_PLAYER_Y, rnd_q());
      csr_write(CSR_HALF_W, rnd_half());
      csr_write(CSR_HALF_H, rnd_half());
      csr_write(CSR_MARGIN, rnd_q());
      csr_write(CSR_HORIZON, $urandom_range(1, 12));
      csr_write(CSR_COUNT, $urandom_range(0, c));
   endtask

   task automatic random_eval();
      if ($urandom_range(0, 9) == 0)
         evaluate($urandom, $urandom);
      else
         evaluate($urandom_range(0, cur_hz), $urandom_range(0, cur_hz));
   endtask

   initial begin
      reset = 1;
      csr_we = 0; csr_index = 0; csr_data = 0;
      req_ch.valid = 0; req_ch.action = 0; req_ch.slot = 0;
      req_ch.pos_x = 0; req_ch.pos_y = 0; req_ch.vel_x = 0; req_ch.vel_y = 0;
      req_ch.acc_x = 0; req_ch.acc_y = 0; req_ch.half_w = 0; req_ch.half_h = 0;
      req_ch.graze_frames = 0; req_ch.startup_frames = 0;
      idle_pct = 0; stall_pct = 0; hold_go = 0;
      n_load = 0; n_eval = 0; contig = 0; cur_hz = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: no projectiles at reset settings
      evaluate(0, 0);
      evaluate(1, 0);
      for (int i = 0; i < 8; i++) load(i);
      csr_write(CSR_PLAYER_X, 32'h80000000);
      csr_write(CSR_PLAYER_Y, 32'h7FFFFFFF);
      csr_write(CSR_HALF_W, 31'h7FFFFFFF);
      csr_write(CSR_HALF_H, 0);
      csr_write(CSR_MARGIN, 32'h7FFFFFFF);
      csr_write(CSR_HORIZON, 0);
      csr_write(CSR_COUNT, 4);
      evaluate(0, 0);
      evaluate(0, 2);
      csr_write(CSR_HORIZON, 8);
      csr_write(CSR_MARGIN, 32'h80000000);
      csr_write(CSR_PLAYER_X, 0);
      csr_write(CSR_PLAYER_Y, 0);
      csr_write(CSR_HALF_W, 32'h00010000);
      csr_write(CSR_HALF_H, 32'h00010000);
      evaluate(8, 0);
      evaluate(3, 9);
      evaluate(10'h3FF, 10'h3FF);
      evaluate(2, 3);
      evaluate(0, 8);
      csr_write(CSR_HORIZON, 10'h3FF);
      csr_write(CSR_COUNT, 1);
      evaluate(599, 1);
      evaluate(0, 600);
      csr_write(CSR_MARGIN, 0);
      csr_write(CSR_COUNT, 8);
      csr_write(CSR_HORIZON, 4);
      evaluate(1, 1);

      for (int ph = 0; ph < 4; ph++) begin
         random_setup();
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  hold_go = 1; end
            1: begin idle_pct = 69; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 69; end
            default: begin idle_pct = 27; stall_pct = 27; end
         endcase
         for (int k = 0; k < 25; k++) begin
            if ($urandom_range(0, 9) < 3)
               load($urandom_range(0, contig < 12 ? contig : 12));
            else
               random_eval();
         end
      end

      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d load words and %0d evaluate words over four idle mixes",
               n_load, n_eval);
      if (fail_count == 0 && pending == 0)
         $display("moving_box_path_hazard_check test passed");
      else
         $display("moving_box_path_hazard_check test failed");
      $finish;
   end

endmodule
